/* design/tbm_pkg.sv */
// Package for the temperature batch monitor.
// Holds the payload structs, register indexes, limits and reset values.
// No dependencies; every other design file imports it.
`default_nettype none

package tbm_pkg;

  localparam int MaxReadings = 128;
  localparam int PosLimit    = ((MaxReadings - 1) < 127) ? (MaxReadings - 1) : 127;
  localparam int NumW        = 27;
  localparam int DivSteps    = NumW;

  localparam logic [6:0]  POS_LIMIT      = 7'(PosLimit);
  localparam logic [7:0]  COUNT_MAX      = 8'hFF;
  localparam logic [22:0] SUM_MAX        = 23'h7F_FFFF;
  localparam logic [18:0] AVG_MAX        = 19'd327670;
  localparam logic [14:0] MIN_RESET      = 15'h7FFF;
  localparam logic [14:0] WARNING_RESET  = 15'd300;
  localparam logic [14:0] CRITICAL_RESET = 15'd450;
  localparam logic [14:0] SHUTDOWN_RESET = 15'd600;

  typedef enum logic [1:0] {
    REG_WARNING  = 2'd0,
    REG_CRITICAL = 2'd1,
    REG_SHUTDOWN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] reading;
    logic               last_reading;
  } tbm_in_t;

  typedef struct packed {
    logic [14:0] min_value;
    logic [14:0] max_value;
    logic [18:0] average_value;
    logic [7:0]  error_count;
    logic [7:0]  normal_count;
    logic [7:0]  warning_count;
    logic [7:0]  critical_count;
    logic [7:0]  shutdown_count;
    logic        first_found;
    logic [6:0]  first_index;
    logic [14:0] first_value;
  } tbm_out_t;

  // Raw statistics of one finished batch, before the average is formed.
  typedef struct packed {
    logic [14:0] min_value;
    logic [14:0] max_value;
    logic [22:0] sum;
    logic [7:0]  valid_total;
    logic [7:0]  error_count;
    logic [7:0]  normal_count;
    logic [7:0]  warning_count;
    logic [7:0]  critical_count;
    logic [7:0]  shutdown_count;
    logic        first_found;
    logic [6:0]  first_index;
    logic [14:0] first_value;
  } tbm_batch_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : 8'(c + 8'd1);
  endfunction

endpackage

`default_nettype wire

/* design/tbm_front.sv */
// Front end of the temperature batch monitor: threshold registers and per-reading statistics.
// Accepts one reading per cycle while the queue is not full and pushes a batch record on the last one. Uses tbm_pkg.
`default_nettype none

module tbm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [14:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tbm_pkg::tbm_in_t  in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output tbm_pkg::tbm_batch_t    q_data
);
  import tbm_pkg::*;

  logic [14:0] warning_level;
  logic [14:0] critical_level;
  logic [14:0] shutdown_level;

  tbm_batch_t  stats;
  tbm_batch_t  stats_next;
  tbm_batch_t  stats_clear;
  logic [6:0]  position;
  logic [6:0]  position_next;
  logic        accept;
  logic        is_err;
  logic [14:0] r;
  logic [23:0] sum_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      warning_level  <= WARNING_RESET;
      critical_level <= CRITICAL_RESET;
      shutdown_level <= SHUTDOWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARNING:  warning_level  <= cfg_data;
        REG_CRITICAL: critical_level <= cfg_data;
        REG_SHUTDOWN: shutdown_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_err   = in_data.reading[15];
  assign r        = in_data.reading[14:0];
  assign sum_wide = {1'b0, stats.sum} + {9'd0, r};

  always_comb begin
    stats_clear           = '0;
    stats_clear.min_value = MIN_RESET;
  end

  always_comb begin
    stats_next    = stats;
    position_next = (position < POS_LIMIT) ? 7'(position + 7'd1) : position;
    if (is_err) begin
      stats_next.error_count = sat_inc(stats.error_count);
    end else begin
      if (r < stats.min_value) stats_next.min_value = r;
      if (r > stats.max_value) stats_next.max_value = r;
      stats_next.sum = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[22:0];
      stats_next.valid_total = sat_inc(stats.valid_total);
      priority if (r < warning_level) begin
        stats_next.normal_count = sat_inc(stats.normal_count);
      end else if (r < critical_level) begin
        stats_next.warning_count = sat_inc(stats.warning_count);
      end else if (r < shutdown_level) begin
        stats_next.critical_count = sat_inc(stats.critical_count);
      end else begin
        stats_next.shutdown_count = sat_inc(stats.shutdown_count);
      end
      if (!stats.first_found && (r >= critical_level)) begin
        stats_next.first_found = 1'b1;
        stats_next.first_index = position;
        stats_next.first_value = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_reading)) begin
      stats    <= stats_clear;
      position <= '0;
    end else if (accept) begin
      stats    <= stats_next;
      position <= position_next;
    end
  end

  assign q_push = accept && in_data.last_reading;
  assign q_data = stats_next;

endmodule

`default_nettype wire

/* design/tbm_queue.sv */
// Two-entry queue of finished batch records between the front and back ends.
// Uses tbm_pkg for the record type.
`default_nettype none

module tbm_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tbm_pkg::tbm_batch_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output tbm_pkg::tbm_batch_t      pop_data,
  output logic                     empty
);
  import tbm_pkg::*;

  tbm_batch_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= 2'(count + 2'd1);
      else if (do_pop && !do_push) count <= 2'(count - 2'd1);
    end
  end

endmodule

`default_nettype wire

/* design/tbm_back.sv */
// Back end of the temperature batch monitor: forms the rounded average with a
// bit-serial divider and holds the summary in the output register. Uses tbm_pkg.
`default_nettype none

module tbm_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire tbm_pkg::tbm_batch_t q_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tbm_pkg::tbm_out_t        out_data
);
  import tbm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t            state;
  logic [NumW-1:0]   work;
  logic [7:0]        rem;
  logic [7:0]        divisor;
  logic [4:0]        step_cnt;
  logic [NumW-1:0]   numer;
  logic [8:0]        rem_shift;
  logic              qbit;
  logic [7:0]        rem_next;
  logic [NumW-1:0]   work_next;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_valid = (state == S_OUT);

  assign numer = {1'b0, q_data.sum, 3'b000} + {3'b000, q_data.sum, 1'b0}
               + {20'd0, q_data.valid_total[7:1]};

  assign rem_shift = {rem, work[NumW-1]};
  assign qbit      = (rem_shift >= {1'b0, divisor});
  assign rem_next  = qbit ? 8'(rem_shift - {1'b0, divisor}) : rem_shift[7:0];
  assign work_next = {work[NumW-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) state <= (q_data.valid_total == 8'd0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (step_cnt == 5'd1) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        work     <= numer;
        rem      <= '0;
        divisor  <= q_data.valid_total;
        step_cnt <= 5'(DivSteps);
        out_data.min_value      <= (q_data.valid_total == 8'd0) ? 15'd0 : q_data.min_value;
        out_data.max_value      <= (q_data.valid_total == 8'd0) ? 15'd0 : q_data.max_value;
        out_data.average_value  <= '0;
        out_data.error_count    <= q_data.error_count;
        out_data.normal_count   <= q_data.normal_count;
        out_data.warning_count  <= q_data.warning_count;
        out_data.critical_count <= q_data.critical_count;
        out_data.shutdown_count <= q_data.shutdown_count;
        out_data.first_found    <= q_data.first_found;
        out_data.first_index    <= q_data.first_index;
        out_data.first_value    <= q_data.first_value;
      end
      S_DIV: begin
        work     <= work_next;
        rem      <= rem_next;
        step_cnt <= 5'(step_cnt - 5'd1);
        if (step_cnt == 5'd1) begin
          out_data.average_value <= (work_next > {8'd0, AVG_MAX}) ? AVG_MAX : work_next[18:0];
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/temperature_batch_monitor.sv */
// Top level of the temperature batch monitor.
// Instantiates tbm_front, tbm_queue and tbm_back; uses tbm_pkg.
//
// The block takes one reading per cycle while in_stall is low. The front end
// registers the batch statistics on each accepted reading and, on the last
// reading, places a batch record in a two-entry queue. The back end forms the
// average with a one-bit-per-cycle divider of 27 steps; a summary is held in
// the output register until it is transferred. in_stall is high only while
// both queue entries are taken, which happens when batches end faster than the
// back end drains the queue or the output stays stalled.
`default_nettype none

module temperature_batch_monitor (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [14:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tbm_pkg::tbm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tbm_pkg::tbm_out_t     out_data
);
  import tbm_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  tbm_batch_t q_wdata;
  tbm_batch_t q_rdata;

  tbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  tbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
